// ===== rtl/arp_resolver_with_cache_defines.svh =====
// ----------------------------------------------------------------------------
// ARP resolver assertion macros
// Shared property forms for the resolver's checker.
// ----------------------------------------------------------------------------
`ifndef ARP_RESOLVER_WITH_CACHE_DEFINES_SVH
`define ARP_RESOLVER_WITH_CACHE_DEFINES_SVH

// same-cycle implication, reset gated
`define ARC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset gated
`define ARC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/arc_pkg.sv =====
// ----------------------------------------------------------------------------
// ARP resolver package
// Types, codes and constants shared by the resolver modules.
// ----------------------------------------------------------------------------
package arc_pkg;

    localparam int CACHE_ENTRIES_DEF = 8;
    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int WAIT_W = 16;
    localparam int LEN_W  = 11;
    localparam int AOP_W  = 16;
    localparam int CFG_W  = 32;
    localparam int CIDX_W = 2;

    localparam logic [LEN_W-1:0]  ARP_MIN_LEN     = LEN_W'(28);
    localparam logic [AOP_W-1:0]  ARP_OP_REPLY    = AOP_W'(2);
    localparam logic [WAIT_W-1:0] FIRST_WAIT_RST  = WAIT_W'(2000);
    localparam logic [WAIT_W-1:0] SECOND_WAIT_RST = WAIT_W'(3000);

    typedef enum logic [1:0] {
        OP_RESOLVE = 2'd0,
        OP_FRAME   = 2'd1,
        OP_TICK    = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        EV_HIT      = 3'd0,
        EV_RESOLVED = 3'd1,
        EV_SEND     = 3'd2,
        EV_FAILED   = 3'd3,
        EV_BUSY     = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WAIT1 = 2'd1,
        PH_WAIT2 = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SCAN = 2'd1,
        ST_RX_T = 2'd2,
        ST_RX_S = 2'd3
    } state_t;

    typedef enum logic [CIDX_W-1:0] {
        REG_OWN_IP      = 2'd0,
        REG_FIRST_WAIT  = 2'd1,
        REG_SECOND_WAIT = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [IP_W-1:0]   own_ip;
        logic [WAIT_W-1:0] first_wait;
        logic [WAIT_W-1:0] second_wait;
    } cfg_t;

endpackage

// ===== rtl/arc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module arc_ram #(
    parameter int WIDTH  = 80,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== rtl/arc_cmp.sv =====
// ----------------------------------------------------------------------------
// Address compare unit
// Shared 32-bit equality compare used by the cache scan and both reply-check steps.
// ----------------------------------------------------------------------------
module arc_cmp (
    input  logic [arc_pkg::IP_W-1:0] a,
    input  logic [arc_pkg::IP_W-1:0] b,
    output logic                     eq
);

    assign eq = ((a ^ b) == '0);

endmodule

// ===== rtl/arc_seq.sv =====
// ----------------------------------------------------------------------------
// ARP resolver sequencer
// Cache scan, reply check, wait countdown and result register.
// ----------------------------------------------------------------------------
module arc_seq #(
    parameter int CACHE_ENTRIES = arc_pkg::CACHE_ENTRIES_DEF,
    parameter int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  arc_pkg::cfg_t               cfg,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  opcode,
    input  logic [arc_pkg::IP_W-1:0]    target_ip,
    input  logic [arc_pkg::LEN_W-1:0]   rx_length,
    input  logic [arc_pkg::AOP_W-1:0]   rx_arp_op,
    input  logic [arc_pkg::IP_W-1:0]    rx_sender_ip,
    input  logic [arc_pkg::IP_W-1:0]    rx_target_ip,
    input  logic [arc_pkg::MAC_W-1:0]   rx_sender_mac,
    output logic                        ram_we,
    output logic [IDX_W-1:0]            ram_waddr,
    output logic [arc_pkg::IP_W+arc_pkg::MAC_W-1:0] ram_wdata,
    output logic [IDX_W-1:0]            ram_raddr,
    input  logic [arc_pkg::IP_W+arc_pkg::MAC_W-1:0] ram_rdata,
    output logic                        done,
    output logic [2:0]                  event_res,
    output logic [arc_pkg::MAC_W-1:0]   resolved_mac,
    output logic [arc_pkg::IP_W-1:0]    request_ip
);

    localparam logic [IDX_W-1:0] LAST = IDX_W'(CACHE_ENTRIES - 1);

    arc_pkg::state_t state_reg, state_next;
    arc_pkg::phase_t phase_reg, phase_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [IDX_W-1:0]            slot_reg, slot_next;
    logic [CACHE_ENTRIES-1:0]    valid_reg, valid_next;
    logic [arc_pkg::IP_W-1:0]    pend_reg, pend_next;
    logic [arc_pkg::WAIT_W-1:0]  count_reg, count_next;
    logic                        tmatch_reg, tmatch_next;
    logic                        done_reg, done_next;
    arc_pkg::event_t             ev_reg, ev_next;
    logic [arc_pkg::MAC_W-1:0]   omac_reg, omac_next;
    logic [arc_pkg::IP_W-1:0]    oip_reg, oip_next;

    logic [arc_pkg::IP_W-1:0]    tip_reg, sip_reg, rtip_reg;
    logic [arc_pkg::LEN_W-1:0]   len_reg;
    logic [arc_pkg::AOP_W-1:0]   aop_reg;
    logic [arc_pkg::MAC_W-1:0]   mac_reg;

    logic [arc_pkg::IP_W-1:0]    cmp_a, cmp_b;
    logic                        cmp_eq;
    logic                        accept;

    arc_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .eq (cmp_eq)
    );

    assign accept    = start && (state_reg == arc_pkg::ST_IDLE);
    assign busy      = (state_reg != arc_pkg::ST_IDLE);
    assign ram_waddr = slot_reg;
    assign ram_wdata = {pend_reg, mac_reg};

    assign done         = done_reg;
    assign event_res    = ev_reg;
    assign resolved_mac = omac_reg;
    assign request_ip   = oip_reg;

    // latch the accepted beat and register the result fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tip_reg  <= target_ip;
            len_reg  <= rx_length;
            aop_reg  <= rx_arp_op;
            sip_reg  <= rx_sender_ip;
            rtip_reg <= rx_target_ip;
            mac_reg  <= rx_sender_mac;
        end
        omac_reg <= omac_next;
        oip_reg  <= oip_next;
        ev_reg   <= ev_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= arc_pkg::ST_IDLE;
            phase_reg  <= arc_pkg::PH_IDLE;
            idx_reg    <= '0;
            slot_reg   <= '0;
            valid_reg  <= '0;
            pend_reg   <= '0;
            count_reg  <= '0;
            tmatch_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            slot_reg   <= slot_next;
            valid_reg  <= valid_next;
            pend_reg   <= pend_next;
            count_reg  <= count_next;
            tmatch_reg <= tmatch_next;
            done_reg   <= done_next;
        end
    end

    always_comb
    begin
        unique case (state_reg)
            arc_pkg::ST_SCAN:
            begin
                cmp_a = ram_rdata[arc_pkg::IP_W+arc_pkg::MAC_W-1:arc_pkg::MAC_W];
                cmp_b = tip_reg;
            end
            arc_pkg::ST_RX_T:
            begin
                cmp_a = rtip_reg;
                cmp_b = cfg.own_ip;
            end
            arc_pkg::ST_RX_S:
            begin
                cmp_a = sip_reg;
                cmp_b = pend_reg;
            end
            default:
            begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        slot_next   = slot_reg;
        valid_next  = valid_reg;
        pend_next   = pend_reg;
        count_next  = count_reg;
        tmatch_next = tmatch_reg;
        done_next   = 1'b0;
        ev_next     = ev_reg;
        omac_next   = omac_reg;
        oip_next    = oip_reg;
        ram_we      = 1'b0;
        ram_raddr   = '0;

        unique case (state_reg)
            arc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (opcode)
                        arc_pkg::OP_RESOLVE:
                        begin
                            if (phase_reg != arc_pkg::PH_IDLE)
                            begin
                                done_next = 1'b1;
                                ev_next   = arc_pkg::EV_BUSY;
                                omac_next = '0;
                                oip_next  = target_ip;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = arc_pkg::ST_SCAN;
                            end
                        end
                        arc_pkg::OP_FRAME:
                        begin
                            if (phase_reg != arc_pkg::PH_IDLE)
                            begin
                                state_next = arc_pkg::ST_RX_T;
                            end
                        end
                        arc_pkg::OP_TICK:
                        begin
                            if (phase_reg != arc_pkg::PH_IDLE)
                            begin
                                if (count_reg > arc_pkg::WAIT_W'(1))
                                begin
                                    count_next = count_reg - arc_pkg::WAIT_W'(1);
                                end
                                else if (phase_reg == arc_pkg::PH_WAIT1)
                                begin
                                    phase_next = arc_pkg::PH_WAIT2;
                                    count_next = cfg.second_wait;
                                    done_next  = 1'b1;
                                    ev_next    = arc_pkg::EV_SEND;
                                    omac_next  = '0;
                                    oip_next   = pend_reg;
                                end
                                else
                                begin
                                    phase_next = arc_pkg::PH_IDLE;
                                    count_next = '0;
                                    done_next  = 1'b1;
                                    ev_next    = arc_pkg::EV_FAILED;
                                    omac_next  = '0;
                                    oip_next   = pend_reg;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            arc_pkg::ST_SCAN:
            begin
                ram_raddr = idx_reg + IDX_W'(1);
                idx_next  = idx_reg + IDX_W'(1);
                if (valid_reg[idx_reg] && cmp_eq)
                begin
                    done_next  = 1'b1;
                    ev_next    = arc_pkg::EV_HIT;
                    omac_next  = ram_rdata[arc_pkg::MAC_W-1:0];
                    oip_next   = tip_reg;
                    state_next = arc_pkg::ST_IDLE;
                end
                else if (idx_reg == LAST)
                begin
                    pend_next  = tip_reg;
                    phase_next = arc_pkg::PH_WAIT1;
                    count_next = cfg.first_wait;
                    done_next  = 1'b1;
                    ev_next    = arc_pkg::EV_SEND;
                    omac_next  = '0;
                    oip_next   = tip_reg;
                    state_next = arc_pkg::ST_IDLE;
                end
            end
            arc_pkg::ST_RX_T:
            begin
                tmatch_next = cmp_eq && (len_reg >= arc_pkg::ARP_MIN_LEN)
                              && (aop_reg == arc_pkg::ARP_OP_REPLY);
                state_next  = arc_pkg::ST_RX_S;
            end
            arc_pkg::ST_RX_S:
            begin
                state_next = arc_pkg::ST_IDLE;
                if (tmatch_reg && cmp_eq)
                begin
                    ram_we              = 1'b1;
                    valid_next[slot_reg] = 1'b1;
                    slot_next  = (slot_reg == LAST) ? '0 : slot_reg + IDX_W'(1);
                    phase_next = arc_pkg::PH_IDLE;
                    count_next = '0;
                    done_next  = 1'b1;
                    ev_next    = arc_pkg::EV_RESOLVED;
                    omac_next  = mac_reg;
                    oip_next   = pend_reg;
                end
            end
        endcase
    end

endmodule

// ===== rtl/arp_resolver_with_cache.sv =====
// ----------------------------------------------------------------------------
// ARP resolver with cache
// Resolves IPv4 addresses to MAC addresses through a small round-robin cache,
// broadcast requests, one retransmission and a reply check.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. A resolve beat scans the
// cache one entry per cycle through the cache RAM's single read port, with busy
// high throughout; its result strobes at the end of the scan or earlier on a
// hit. A received frame during a wait goes through two compare steps on the
// shared address comparator. A tick, a refused resolve, a frame while idle or
// an unused opcode is handled in the accept cycle and busy stays low; a
// result, where there is one, strobes on the next cycle. Each result is on the
// ports for one cycle with done high; the receiver cannot stall it, so take it
// when it shows. The cache valid bits clear at reset, with no clearing pass.
module arp_resolver_with_cache #(
    parameter int CACHE_ENTRIES = arc_pkg::CACHE_ENTRIES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [arc_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [arc_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  opcode,
    input  logic [arc_pkg::IP_W-1:0]    target_ip,
    input  logic [arc_pkg::LEN_W-1:0]   rx_length,
    input  logic [arc_pkg::AOP_W-1:0]   rx_arp_op,
    input  logic [arc_pkg::IP_W-1:0]    rx_sender_ip,
    input  logic [arc_pkg::IP_W-1:0]    rx_target_ip,
    input  logic [arc_pkg::MAC_W-1:0]   rx_sender_mac,
    output logic                        done,
    output logic [2:0]                  event_res,
    output logic [arc_pkg::MAC_W-1:0]   resolved_mac,
    output logic [arc_pkg::IP_W-1:0]    request_ip
);

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int ENT_W = arc_pkg::IP_W + arc_pkg::MAC_W;

    arc_pkg::cfg_t cfg_reg;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_ip      <= '0;
            cfg_reg.first_wait  <= arc_pkg::FIRST_WAIT_RST;
            cfg_reg.second_wait <= arc_pkg::SECOND_WAIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                arc_pkg::REG_OWN_IP:      cfg_reg.own_ip      <= cfg_data;
                arc_pkg::REG_FIRST_WAIT:  cfg_reg.first_wait  <= cfg_data[arc_pkg::WAIT_W-1:0];
                arc_pkg::REG_SECOND_WAIT: cfg_reg.second_wait <= cfg_data[arc_pkg::WAIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    arc_ram #(
        .WIDTH  (ENT_W),
        .DEPTH  (CACHE_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_cache (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    arc_seq #(
        .CACHE_ENTRIES (CACHE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .target_ip     (target_ip),
        .rx_length     (rx_length),
        .rx_arp_op     (rx_arp_op),
        .rx_sender_ip  (rx_sender_ip),
        .rx_target_ip  (rx_target_ip),
        .rx_sender_mac (rx_sender_mac),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .done          (done),
        .event_res     (event_res),
        .resolved_mac  (resolved_mac),
        .request_ip    (request_ip)
    );

endmodule

// ===== rtl/arc_checker.sv =====
// ----------------------------------------------------------------------------
// ARP resolver checker
// Port-level timing and result checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "arp_resolver_with_cache_defines.svh"

module arc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [1:0]                  opcode,
    input logic                        done,
    input logic [2:0]                  event_res,
    input logic [arc_pkg::MAC_W-1:0]   resolved_mac
);

    logic take_tick;
    logic take_frame;
    logic no_mac_ev;

    assign take_tick  = start && !busy && (opcode == arc_pkg::OP_TICK);
    assign take_frame = start && !busy && (opcode == arc_pkg::OP_FRAME);
    assign no_mac_ev  = done && ((event_res == arc_pkg::EV_SEND)
                                 || (event_res == arc_pkg::EV_FAILED)
                                 || (event_res == arc_pkg::EV_BUSY));

    `ARC_ASSERT_IMP(a_done_idle, done, !busy, "result shown while busy")
    `ARC_ASSERT_IMP(a_mac_zero, no_mac_ev, resolved_mac == '0, "nonzero MAC on a no-address event")
    `ARC_ASSERT_NXT(a_tick_fast, take_tick, !busy, "tick beat held the block busy")
    `ARC_ASSERT_NXT(a_frame_late, take_frame, !done, "frame result too early")

endmodule

bind arp_resolver_with_cache arc_checker u_arc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .done         (done),
    .event_res    (event_res),
    .resolved_mac (resolved_mac)
);
